// ===== rtl/assembly_mnemonic_lexer_macros.svh =====
// Assertion macros for the mnemonic lexer.
`ifndef ASSEMBLY_MNEMONIC_LEXER_MACROS_SVH
`define ASSEMBLY_MNEMONIC_LEXER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled during reset.
`define AML_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define AML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define AML_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define AML_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/aml_pkg.sv =====
package aml_pkg;

    // Token kinds
    localparam logic [1:0] KIND_NUMBER   = 2'd0;
    localparam logic [1:0] KIND_MNEMONIC = 2'd1;
    localparam logic [1:0] KIND_UNKNOWN  = 2'd2;
    localparam logic [1:0] KIND_BAD      = 2'd3;

    // Class of a word's first byte
    localparam logic [1:0] CLASS_DIGIT  = 2'd0;
    localparam logic [1:0] CLASS_LETTER = 2'd1;
    localparam logic [1:0] CLASS_OTHER  = 2'd2;

    // Separator bytes
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

    localparam int MNEM_COUNT = 11;

    // HLT ADD SUB STA LDA BRA BRZ BRP INP OUT DAT, first letter highest
    localparam logic [23:0] MNEM_TABLE [MNEM_COUNT] = '{
        24'h484C54, 24'h414444, 24'h535542, 24'h535441,
        24'h4C4441, 24'h425241, 24'h42525A, 24'h425250,
        24'h494E50, 24'h4F5554, 24'h444154
    };

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_text;
    } char_item_t;

    typedef struct packed {
        logic [1:0]  token_kind;
        logic [15:0] number_value;
        logic [3:0]  mnemonic_index;
        logic        final_token;
    } token_item_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] index;
    } mnem_match_t;

    // Exact lookup of three stored letters in the mnemonic table
    function automatic mnem_match_t mnem_lookup(input logic [23:0] letters);
        mnem_match_t m;
        m.hit   = 1'b0;
        m.index = '0;
        for (int i = 0; i < MNEM_COUNT; i++)
        begin
            if (!m.hit && letters == MNEM_TABLE[i])
            begin
                m.hit   = 1'b1;
                m.index = 4'(i);
            end
        end
        return m;
    endfunction

endpackage

// ===== rtl/assembly_mnemonic_lexer.sv =====
// Mnemonic lexer: takes one source byte per cycle on the char channel and
// emits one token per finished word on the token channel. Every byte is
// handled by the combinational word-state update; a token appears in the
// output register the cycle after the byte that closes its word, and a new
// byte is taken in the same cycle that a waiting token is taken, so the
// sustained rate is one byte per cycle. The byte path stalls only while a
// token sits unaccepted in the output register.
`include "assembly_mnemonic_lexer_macros.svh"

module assembly_mnemonic_lexer #(
    parameter int VALUE_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 char_valid,
    output logic                 char_ready,
    input  aml_pkg::char_item_t  char_item,
    output logic                 token_valid,
    input  logic                 token_ready,
    output aml_pkg::token_item_t token_item
);
    import aml_pkg::*;

    // Stored value width, capped by the 16-bit result field
    localparam int LIM_BITS = (VALUE_BITS > 16) ? 16 : VALUE_BITS;
    localparam int PROD_BITS = LIM_BITS + 4;
    localparam logic [PROD_BITS-1:0] LIMIT = {4'b0, {LIM_BITS{1'b1}}};

    // Word state
    logic                inside_word_reg, inside_word_next;
    logic [1:0]          class_reg, class_next;
    logic [23:0]         letters_reg, letters_next;
    logic [2:0]          count_reg, count_next;
    logic [LIM_BITS-1:0] digit_reg, digit_next;
    logic                open_reg, open_next;

    // Output register
    logic        token_valid_reg;
    token_item_t token_item_reg;

    logic        accept;
    logic        sep;
    logic        is_digit;
    logic        is_upper;
    logic        emit;
    logic        fin;
    token_item_t result;
    mnem_match_t match;

    // Word view used for emission (updated state, or held state on a separator)
    logic [1:0]          w_class;
    logic [23:0]         w_letters;
    logic [2:0]          w_count;
    logic [LIM_BITS-1:0] w_digit;

    // Intermediate word state after a possible new-word start
    logic [23:0]          b_letters;
    logic [2:0]           b_count;
    logic [LIM_BITS-1:0]  b_digit;
    logic                 b_open;
    logic [PROD_BITS-1:0] prod;

    assign char_ready  = !token_valid_reg || token_ready;
    assign accept      = char_valid && char_ready;
    assign token_valid = token_valid_reg;
    assign token_item  = token_item_reg;

    // Byte classification
    always_comb
    begin
        sep = (char_item.char_code == CHAR_SPACE) || (char_item.char_code == CHAR_TAB)
              || (char_item.char_code == CHAR_NEWLINE);
        is_digit = (char_item.char_code >= 8'h30) && (char_item.char_code <= 8'h39);
        is_upper = (char_item.char_code >= 8'h41) && (char_item.char_code <= 8'h5A);
    end

    // Word-state update for one byte
    always_comb
    begin
        class_next = class_reg;
        b_letters  = letters_reg;
        b_count    = count_reg;
        b_digit    = digit_reg;
        b_open     = open_reg;
        if (!inside_word_reg)
        begin
            if (is_digit)
                class_next = CLASS_DIGIT;
            else if (is_upper)
                class_next = CLASS_LETTER;
            else
                class_next = CLASS_OTHER;
            b_letters = '0;
            b_count   = '0;
            b_digit   = '0;
            b_open    = 1'b1;
        end

        // Times ten plus digit, saturated
        prod = ({4'b0, b_digit} << 3) + ({4'b0, b_digit} << 1)
               + PROD_BITS'(char_item.char_code[3:0]);
        if (b_open && is_digit)
        begin
            digit_next = (prod > LIMIT) ? LIMIT[LIM_BITS-1:0] : prod[LIM_BITS-1:0];
            open_next  = 1'b1;
        end
        else
        begin
            digit_next = b_digit;
            open_next  = 1'b0;
        end

        if (b_count < 3'd3)
        begin
            letters_next = {b_letters[15:0], char_item.char_code};
            count_next   = b_count + 3'd1;
        end
        else
        begin
            letters_next = b_letters;
            count_next   = 3'd4;
        end
    end

    // Token formation
    always_comb
    begin
        if (sep)
        begin
            w_class   = class_reg;
            w_letters = letters_reg;
            w_count   = count_reg;
            w_digit   = digit_reg;
        end
        else
        begin
            w_class   = class_next;
            w_letters = letters_next;
            w_count   = count_next;
            w_digit   = digit_next;
        end
        match = mnem_lookup(w_letters);
        fin   = char_item.end_of_text;

        result.token_kind     = KIND_BAD;
        result.number_value   = '0;
        result.mnemonic_index = '0;
        result.final_token    = fin;
        if (sep && !inside_word_reg)
        begin
            result.token_kind = KIND_BAD;
        end
        else
        begin
            unique case (w_class)
                CLASS_DIGIT:
                begin
                    result.token_kind   = KIND_NUMBER;
                    result.number_value = 16'(w_digit);
                end
                CLASS_LETTER:
                begin
                    if (w_count == 3'd3 && match.hit)
                    begin
                        result.token_kind     = KIND_MNEMONIC;
                        result.mnemonic_index = match.index;
                    end
                    else
                    begin
                        result.token_kind = KIND_UNKNOWN;
                    end
                end
                default:
                begin
                    result.token_kind = KIND_BAD;
                end
            endcase
        end

        emit = fin || (sep && inside_word_reg);
        inside_word_next = !sep && !fin;
    end

    // State and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_word_reg <= 1'b0;
            class_reg       <= '0;
            letters_reg     <= '0;
            count_reg       <= '0;
            digit_reg       <= '0;
            open_reg        <= 1'b0;
            token_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                inside_word_reg <= inside_word_next;
                if (!sep)
                begin
                    class_reg   <= class_next;
                    letters_reg <= letters_next;
                    count_reg   <= count_next;
                    digit_reg   <= digit_next;
                    open_reg    <= open_next;
                end
            end
            if (accept && emit)
                token_valid_reg <= 1'b1;
            else if (token_ready)
                token_valid_reg <= 1'b0;
        end
    end

    // Output payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            token_item_reg <= result;
    end

    // Checks
    `AML_ASSERT_NOW(a_value_only_number, clk, rst_n,
        token_valid && token_item.token_kind != KIND_NUMBER,
        token_item.number_value == 16'd0, "number value set on a non-number token")
    `AML_ASSERT_NOW(a_index_only_mnem, clk, rst_n,
        token_valid && token_item.token_kind != KIND_MNEMONIC,
        token_item.mnemonic_index == 4'd0, "mnemonic index set on a non-mnemonic token")
    `AML_ASSERT_NEXT(a_eot_closes, clk, rst_n,
        accept && char_item.end_of_text,
        token_valid && token_item.final_token && !inside_word_reg,
        "end of text did not close the word with a final token")
    `AML_ASSERT_NEXT(a_word_byte_opens, clk, rst_n,
        accept && !sep && !char_item.end_of_text,
        inside_word_reg, "word byte did not leave a word pending")

endmodule

// ===== test/lexer_scoreboard_pkg.sv =====
package lexer_scoreboard_pkg;

    import aml_pkg::*;

    // Value width the block is built with, and the saturation point it implies
    localparam int          VALUE_BITS  = 16;
    localparam int unsigned VALUE_LIMIT = (VALUE_BITS >= 16) ? 32'd65535
                                                             : (32'd1 << VALUE_BITS) - 32'd1;

    // Tracks the word state of the lexer and holds the tokens still to come
    class token_scoreboard;

        bit          in_word;
        logic [1:0]  first_class;
        logic [23:0] letters;
        int unsigned letter_cnt;
        logic [15:0] digit_acc;
        bit          digits_open;

        token_item_t tokens_due[$];
        int          errors;

        function new();
            in_word     = 1'b0;
            first_class = CLASS_DIGIT;
            letters     = '0;
            letter_cnt  = 0;
            digit_acc   = '0;
            digits_open = 1'b0;
            errors      = 0;
        endfunction

        function int pending();
            return tokens_due.size();
        endfunction

        // Token for the pending word
        function token_item_t word_token(bit fin);
            token_item_t tok;
            tok = '0;
            tok.final_token = fin;
            if (first_class == CLASS_DIGIT)
            begin
                tok.token_kind   = KIND_NUMBER;
                tok.number_value = digit_acc;
            end
            else if (first_class == CLASS_LETTER)
            begin
                tok.token_kind = KIND_UNKNOWN;
                if (letter_cnt == 3)
                begin
                    for (int i = 0; i < MNEM_COUNT; i++)
                    begin
                        if (tok.token_kind == KIND_UNKNOWN && letters == MNEM_TABLE[i])
                        begin
                            tok.token_kind     = KIND_MNEMONIC;
                            tok.mnemonic_index = 4'(i);
                        end
                    end
                end
            end
            else
            begin
                tok.token_kind = KIND_BAD;
            end
            return tok;
        endfunction

        // Advance the word state by one byte; returns 1 when a token closes
        function bit lex_char(char_item_t item, output token_item_t tok);
            logic [7:0]  c;
            bit          sep;
            bit          digit;
            int unsigned acc;
            c     = item.char_code;
            sep   = (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NEWLINE);
            digit = (c >= 8'h30 && c <= 8'h39);
            tok   = '0;
            if (!sep)
            begin
                // first byte of a word sets its class and clears the word state
                if (!in_word)
                begin
                    in_word = 1'b1;
                    if (digit)
                        first_class = CLASS_DIGIT;
                    else if (c >= 8'h41 && c <= 8'h5A)
                        first_class = CLASS_LETTER;
                    else
                        first_class = CLASS_OTHER;
                    letters     = '0;
                    letter_cnt  = 0;
                    digit_acc   = '0;
                    digits_open = 1'b1;
                end
                if (digits_open && digit)
                begin
                    acc       = int'(digit_acc) * 10 + int'(c - 8'h30);
                    digit_acc = 16'((acc > VALUE_LIMIT) ? VALUE_LIMIT : acc);
                end
                else
                begin
                    digits_open = 1'b0;
                end
                if (letter_cnt < 3)
                begin
                    letters    = {letters[15:0], c};
                    letter_cnt = letter_cnt + 1;
                end
                else
                begin
                    letter_cnt = 4;
                end
                if (item.end_of_text)
                begin
                    tok     = word_token(1'b1);
                    in_word = 1'b0;
                    return 1'b1;
                end
                return 1'b0;
            end
            if (in_word)
            begin
                tok     = word_token(item.end_of_text);
                in_word = 1'b0;
                return 1'b1;
            end
            // separator at end of text with no word: empty trailing word
            if (item.end_of_text)
            begin
                tok.token_kind  = KIND_BAD;
                tok.final_token = 1'b1;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        function void note_char(char_item_t item);
            token_item_t tok;
            if (lex_char(item, tok))
                tokens_due.push_back(tok);
        endfunction

        function void fail(string what);
            errors++;
            $display("%0t: %s", $time, what);
        endfunction

        function void check_token(token_item_t got);
            token_item_t want;
            if (tokens_due.size() == 0)
            begin
                fail($sformatf({"unexpected token, expected none, actual kind=%0d value=%0d",
                                " idx=%0d final=%0d"},
                               got.token_kind, got.number_value, got.mnemonic_index,
                               got.final_token));
                return;
            end
            want = tokens_due.pop_front();
            if (got.token_kind !== want.token_kind)
                fail($sformatf("token_kind expected %0d actual %0d",
                               want.token_kind, got.token_kind));
            if (got.number_value !== want.number_value)
                fail($sformatf("number_value expected %0d actual %0d",
                               want.number_value, got.number_value));
            if (got.mnemonic_index !== want.mnemonic_index)
                fail($sformatf("mnemonic_index expected %0d actual %0d",
                               want.mnemonic_index, got.mnemonic_index));
            if (got.final_token !== want.final_token)
                fail($sformatf("final_token expected %0d actual %0d",
                               want.final_token, got.final_token));
        endfunction

    endclass

endpackage

// ===== test/tb_top.sv =====
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import aml_pkg::*;
    import lexer_scoreboard_pkg::*;

    localparam int RANDOM_BYTES = 950;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        char_valid  = 1'b0;
    logic        char_ready;
    char_item_t  char_item   = '0;
    logic        token_valid;
    logic        token_ready = 1'b0;
    token_item_t token_item;

    token_scoreboard sb = new();

    int sent       = 0;
    int burst_left = 0;
    bit hold_req   = 1'b0;

    assembly_mnemonic_lexer #(
        .VALUE_BITS (VALUE_BITS)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_ready  (char_ready),
        .char_item   (char_item),
        .token_valid (token_valid),
        .token_ready (token_ready),
        .token_item  (token_item)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Offer one byte and hold it until taken; gaps fall between bursts
    task automatic send_char(input char_item_t item);
        char_valid <= 1'b1;
        char_item  <= item;
        @(posedge clk);
        while (!char_ready)
            @(posedge clk);
        sb.note_char(item);
        sent++;
        if (burst_left == 0)
        begin
            char_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 8);
        end
        else
        begin
            burst_left--;
        end
    endtask

    task automatic send_text(input string s, input bit eot_last);
        for (int i = 0; i < s.len(); i++)
            send_char({s[i], 1'(eot_last && i == s.len() - 1)});
    endtask

    function automatic logic [7:0] word_byte();
        logic [7:0] c;
        do
            c = 8'($urandom);
        while (c == CHAR_SPACE || c == CHAR_TAB || c == CHAR_NEWLINE);
        return c;
    endfunction

    function automatic logic [7:0] sep_byte();
        case ($urandom_range(0, 2))
            0:       return CHAR_SPACE;
            1:       return CHAR_TAB;
            default: return CHAR_NEWLINE;
        endcase
    endfunction

    // One random word with its separators; end of text now and then
    task automatic send_word();
        logic [7:0] text[$];
        int         pick;
        int         idx;
        int         n;
        int         eot_mode;
        int         nsep;
        pick = $urandom_range(0, 99);
        idx  = $urandom_range(0, MNEM_COUNT - 1);
        if (pick < 30)
        begin
            text = '{MNEM_TABLE[idx][23:16], MNEM_TABLE[idx][15:8], MNEM_TABLE[idx][7:0]};
        end
        else if (pick < 40)
        begin
            // near miss of a mnemonic
            text = '{MNEM_TABLE[idx][23:16], MNEM_TABLE[idx][15:8], MNEM_TABLE[idx][7:0]};
            case ($urandom_range(0, 2))
                0:       text[$urandom_range(0, 2)] = 8'($urandom_range(8'h41, 8'h5A));
                1:       text.push_back(8'($urandom_range(8'h41, 8'h5A)));
                default: repeat ($urandom_range(1, 2)) void'(text.pop_back());
            endcase
        end
        else if (pick < 65)
        begin
            // number, long ones may saturate
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 9) : $urandom_range(1, 4);
            repeat (n) text.push_back(8'($urandom_range(8'h30, 8'h39)));
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3)) text.push_back(($urandom_range(0, 1) == 0)
                    ? word_byte() : 8'($urandom_range(8'h30, 8'h39)));
        end
        else if (pick < 75)
        begin
            repeat ($urandom_range(1, 5)) text.push_back(8'($urandom_range(8'h41, 8'h5A)));
        end
        else if (pick < 90)
        begin
            repeat ($urandom_range(1, 6)) text.push_back(word_byte());
        end
        else if (pick < 95)
        begin
            // lower-case mnemonic spelling
            text = '{MNEM_TABLE[idx][23:16] | 8'h20, MNEM_TABLE[idx][15:8] | 8'h20,
                     MNEM_TABLE[idx][7:0] | 8'h20};
        end
        // else empty word: separators only

        eot_mode = $urandom_range(0, 15);
        if (eot_mode == 0 && text.size() > 0)
        begin
            // end of text on the last word byte
            for (int i = 0; i < text.size(); i++)
                send_char({text[i], 1'(i == text.size() - 1)});
        end
        else
        begin
            foreach (text[i])
                send_char({text[i], 1'b0});
            nsep = $urandom_range(1, 3);
            for (int i = 0; i < nsep; i++)
                send_char({sep_byte(), 1'(eot_mode == 1 && i == nsep - 1)});
        end
    endtask

    // Result side: check accepted tokens, stall on a shifting pattern
    initial
    begin
        int hold_cnt;
        int mode;
        int mode_left;
        int phase;
        hold_cnt  = 0;
        mode      = 0;
        mode_left = 0;
        phase     = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (token_valid && token_ready)
                sb.check_token(token_item);
            if (hold_req && hold_cnt == 0)
            begin
                hold_req = 1'b0;
                hold_cnt = 300;
            end
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 100);
            end
            mode_left--;
            phase++;
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                token_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    0:       token_ready <= 1'b1;
                    1:       token_ready <= 1'($urandom_range(0, 1));
                    2:       token_ready <= ($urandom_range(0, 3) == 0);
                    default: token_ready <= ((phase % 4) != 3);
                endcase
            end
        end
    end

    // Stimulus
    initial
    begin
        bit held;
        bit paused;
        held   = 1'b0;
        paused = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: each token kind, saturation, end-of-text cases, byte extremes
        send_text("HLT ", 1'b0);
        send_text("70000\n", 1'b0);
        send_text("Q9\t", 1'b0);
        send_text("#", 1'b1);
        send_text(" ", 1'b1);
        send_char({8'h39, 1'b0});
        send_char({8'hFF, 1'b0});
        send_char({CHAR_SPACE, 1'b1});
        send_char({8'h0D, 1'b0});
        send_char({8'h00, 1'b0});
        send_char({CHAR_TAB, 1'b0});

        while (sent < RANDOM_BYTES)
        begin
            send_word();
            if (!held && sent >= 350)
            begin
                // long receiver stall while bytes keep coming
                held     = 1'b1;
                hold_req = 1'b1;
            end
            if (!paused && sent >= 650)
            begin
                // sender waits for every token to drain
                paused = 1'b1;
                char_valid <= 1'b0;
                do
                    @(posedge clk);
                while (sb.pending() != 0);
            end
        end

        char_valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
        repeat (10) @(posedge clk);
        if (sb.pending() != 0)
            sb.fail("tokens still expected at end of run");
        if (sb.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/aml_pkg.sv
rtl/assembly_mnemonic_lexer.sv
test/lexer_scoreboard_pkg.sv
test/tb_top.sv
